// ===== hw/rtl/lgs_pkg.sv =====
// Package for the life grid generation step unit.
// Holds grid sizes, field widths, request kinds, the sequencer state type and the row cell
// control struct. It depends on nothing else.
`default_nettype none

package lgs_pkg;

   localparam int MAX_COLUMNS = 64;
   localparam int MAX_ROWS    = 64;

   localparam int COL_W   = $clog2(MAX_COLUMNS);
   localparam int ROW_W   = $clog2(MAX_ROWS);
   localparam int FIELD_W = 6;
   localparam int CFG_W   = 7;
   localparam int KIND_W  = 2;

   localparam int EFF_COL_RAW = $clog2(MAX_COLUMNS + 1);
   localparam int EFF_ROW_RAW = $clog2(MAX_ROWS + 1);
   localparam int EFF_COL_W   = (EFF_COL_RAW > CFG_W) ? EFF_COL_RAW : CFG_W;
   localparam int EFF_ROW_W   = (EFF_ROW_RAW > CFG_W) ? EFF_ROW_RAW : CFG_W;

   localparam int REQ_DATA_W = 16;
   localparam int RSP_DATA_W = 8;

   localparam logic [KIND_W-1:0] KIND_WRITE   = 2'd0;
   localparam logic [KIND_W-1:0] KIND_ADVANCE = 2'd1;
   localparam logic [KIND_W-1:0] KIND_READ    = 2'd2;
   localparam logic [KIND_W-1:0] KIND_CLEAR   = 2'd3;

   localparam logic CSR_COLUMNS = 1'b0;
   localparam logic CSR_ROWS    = 1'b1;

   localparam logic [3:0] BIRTH_COUNT = 4'd3;
   localparam logic [3:0] SURVIVE_LOW = 4'd2;

   typedef enum logic {
      ST_IDLE,
      ST_STEP
   } state_type;

   typedef struct packed {
      logic             shift;
      logic             clear;
      logic             write;
      logic [COL_W-1:0] col;
      logic             value;
   } cell_ctl_type;

endpackage

`default_nettype wire

// ===== hw/rtl/lgs_row_cell.sv =====
// One row cell of the grid chain: holds one row of cells.
// It shifts its row to the neighbor during a generation step and takes writes and clears.
// Depends on lgs_pkg.
`default_nettype none

module lgs_row_cell (
   input  wire                                    clock,
   input  wire                                    reset,
   input  lgs_pkg::cell_ctl_type                  ctl,
   input  wire                                    sel,
   input  wire        [lgs_pkg::MAX_COLUMNS-1:0]  shift_in,
   output logic       [lgs_pkg::MAX_COLUMNS-1:0]  row_out
);
   import lgs_pkg::*;

   logic [MAX_COLUMNS-1:0] row_ff;
   logic [MAX_COLUMNS-1:0] row_in;

   always_comb begin
      row_in = row_ff;
      if (ctl.clear) begin
         row_in = '0;
      end else if (ctl.shift) begin
         row_in = shift_in;
      end else if (ctl.write && sel) begin
         row_in[ctl.col] = ctl.value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff <= '0;
      end else begin
         row_ff <= row_in;
      end
   end

   assign row_out = row_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/lgs_row_update.sv =====
// Next-generation logic for one row: counts the eight neighbors of every cell and applies B3/S23.
// Cells outside the area in use are kept; neighbors outside it count as dead.
// Depends on lgs_pkg.
`default_nettype none

module lgs_row_update (
   input  wire  [lgs_pkg::MAX_COLUMNS-1:0] above,
   input  wire  [lgs_pkg::MAX_COLUMNS-1:0] center,
   input  wire  [lgs_pkg::MAX_COLUMNS-1:0] below,
   input  wire                             above_valid,
   input  wire                             below_valid,
   input  wire                             row_valid,
   input  wire  [lgs_pkg::MAX_COLUMNS-1:0] col_mask,
   output logic [lgs_pkg::MAX_COLUMNS-1:0] next_row
);
   import lgs_pkg::*;

   logic [MAX_COLUMNS+1:0] pad_above;
   logic [MAX_COLUMNS+1:0] pad_center;
   logic [MAX_COLUMNS+1:0] pad_below;

   always_comb begin
      pad_above  = {1'b0, above & col_mask & {MAX_COLUMNS{above_valid}}, 1'b0};
      pad_center = {1'b0, center & col_mask, 1'b0};
      pad_below  = {1'b0, below & col_mask & {MAX_COLUMNS{below_valid}}, 1'b0};
   end

   always_comb begin
      logic [3:0] count;
      logic       alive;
      logic       rule;
      next_row = center;
      for (int c = 0; c < MAX_COLUMNS; c++) begin
         count = 4'(pad_above[c]) + 4'(pad_above[c+1]) + 4'(pad_above[c+2])
               + 4'(pad_center[c]) + 4'(pad_center[c+2])
               + 4'(pad_below[c]) + 4'(pad_below[c+1]) + 4'(pad_below[c+2]);
         alive = center[c];
         rule  = (count == BIRTH_COUNT) || (alive && (count == SURVIVE_LOW));
         if (row_valid && col_mask[c]) begin
            next_row[c] = rule;
         end
      end
   end

endmodule

`default_nettype wire

// ===== hw/rtl/life_grid_generation_step_unit.sv =====
// Game of Life (B3/S23) grid unit on a bounded grid, built as a chain of row cells.
// Depends on lgs_pkg, lgs_row_cell and lgs_row_update.
//
// Requests come in on req_ (tuser = kind, tdata = column, row, new_value); each gives one
// response on rsp_ (cell_alive, out_of_area). Kinds: write cell, advance, read cell, clear.
// Write, read and clear take effect in the cycle the request is accepted and the response is
// valid on the next cycle. Advance rotates the rows once through the chain of row cells,
// and one update unit computes one whole row per cycle as the row passes the head of the
// chain. Its response follows the last rotation cycle.
// One request is in work at a time; a new request is accepted once the previous one is done
// and the response register is empty or being taken in the same cycle.
// When the receiver stalls, the response holds and no new request is accepted.
// The csr_ port writes columns_in_use (index 0) and rows_in_use (index 1); it is always ready.
// Values above the grid size act as the grid size; zero makes the area empty.
// Reset clears the whole grid, sets both sizes to 64 and empties the response.
`default_nettype none

module life_grid_generation_step_unit (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_tvalid,
   output logic        req_tready,
   input  wire  [15:0] req_tdata,  // column [5:0], row [11:6], new_value [12], zeros above
   input  wire  [1:0]  req_tuser,  // kind
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   output logic [7:0]  rsp_tdata,  // cell_alive [0], out_of_area [1], zeros above
   input  wire         csr_valid,
   output logic        csr_ready,
   input  wire         csr_index,
   input  wire  [6:0]  csr_data
);
   import lgs_pkg::*;

   state_type state_ff;
   state_type state_in;

   logic [CFG_W-1:0] cols_ff;
   logic [CFG_W-1:0] rows_ff;
   logic [ROW_W-1:0] cnt_ff;
   logic [ROW_W-1:0] cnt_in;
   logic             rsp_valid_ff;
   logic             rsp_valid_in;
   logic             alive_ff;
   logic             alive_in;
   logic             oob_ff;
   logic             oob_in;
   logic [MAX_COLUMNS-1:0] prev_ff;

   logic [EFF_COL_W-1:0] eff_cols;
   logic [EFF_ROW_W-1:0] eff_rows;
   logic [MAX_COLUMNS-1:0] col_mask;
   logic [MAX_COLUMNS-1:0] rows_w [MAX_ROWS];
   logic [MAX_COLUMNS-1:0] next_row;

   logic [KIND_W-1:0]  req_kind;
   logic [FIELD_W-1:0] req_col;
   logic [FIELD_W-1:0] req_row;
   logic               req_value;
   logic               accept;
   logic               in_area;
   logic               last_step;
   logic               row_valid;
   logic               below_valid;
   cell_ctl_type       ctl;

   assign req_kind  = req_tuser;
   assign req_col   = req_tdata[5:0];
   assign req_row   = req_tdata[11:6];
   assign req_value = req_tdata[12];

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cols_ff <= CFG_W'(64);
         rows_ff <= CFG_W'(64);
      end else if (csr_valid) begin
         if (csr_index == CSR_COLUMNS) begin
            cols_ff <= csr_data;
         end else begin
            rows_ff <= csr_data;
         end
      end
   end

   always_comb begin
      eff_cols = (EFF_COL_W'(cols_ff) > EFF_COL_W'(MAX_COLUMNS)) ?
                 EFF_COL_W'(MAX_COLUMNS) : EFF_COL_W'(cols_ff);
      eff_rows = (EFF_ROW_W'(rows_ff) > EFF_ROW_W'(MAX_ROWS)) ?
                 EFF_ROW_W'(MAX_ROWS) : EFF_ROW_W'(rows_ff);
      for (int c = 0; c < MAX_COLUMNS; c++) begin
         col_mask[c] = 32'(eff_cols) > c;
      end
   end

   assign in_area = (32'(req_col) < 32'(eff_cols)) && (32'(req_row) < 32'(eff_rows));

   assign req_tready  = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_tready);
   assign accept      = req_tvalid && req_tready;
   assign last_step   = cnt_ff == ROW_W'(MAX_ROWS - 1);
   assign row_valid   = EFF_ROW_W'(cnt_ff) < eff_rows;
   assign below_valid = (EFF_ROW_W'(cnt_ff) + EFF_ROW_W'(1)) < eff_rows;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept && (req_kind == KIND_ADVANCE)) begin
               state_in = ST_STEP;
            end
         end
         ST_STEP: begin
            if (last_step) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      ctl          = '0;
      ctl.col      = COL_W'(req_col);
      ctl.value    = req_value;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      alive_in     = alive_ff;
      oob_in       = oob_ff;
      case (state_ff)
         ST_IDLE: begin
            cnt_in = '0;
            if (accept) begin
               ctl.write = (req_kind == KIND_WRITE) && in_area;
               ctl.clear = req_kind == KIND_CLEAR;
               if (req_kind != KIND_ADVANCE) begin
                  rsp_valid_in = 1'b1;
                  alive_in     = (req_kind == KIND_READ) && in_area &&
                                 rows_w[ROW_W'(req_row)][COL_W'(req_col)];
                  oob_in       = ((req_kind == KIND_READ) || (req_kind == KIND_WRITE)) &&
                                 !in_area;
               end
            end
         end
         ST_STEP: begin
            ctl.shift = 1'b1;
            cnt_in    = cnt_ff + ROW_W'(1);
            if (last_step) begin
               rsp_valid_in = 1'b1;
               alive_in     = 1'b0;
               oob_in       = 1'b0;
            end
         end
         default: begin
            cnt_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      alive_ff <= alive_in;
      oob_ff   <= oob_in;
      prev_ff  <= rows_w[0];
   end

   for (genvar k = 0; k < MAX_ROWS; k++) begin : g_rows
      logic [MAX_COLUMNS-1:0] shift_src;
      if (k == MAX_ROWS - 1) begin : g_tail
         assign shift_src = next_row;
      end else begin : g_body
         assign shift_src = rows_w[k+1];
      end
      lgs_row_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .ctl      (ctl),
         .sel      (32'(req_row) == k),
         .shift_in (shift_src),
         .row_out  (rows_w[k])
      );
   end

   lgs_row_update u_update (
      .above       (prev_ff),
      .center      (rows_w[0]),
      .below       (rows_w[1]),
      .above_valid (cnt_ff != '0),
      .below_valid (below_valid),
      .row_valid   (row_valid),
      .col_mask    (col_mask),
      .next_row    (next_row)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'b0, oob_ff, alive_ff};

endmodule

`default_nettype wire
